/* src/slsph_pkg.sv */
// Shared types and constants for the scrolling level scope with peak hold.
package slsph_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCOPE_ENABLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_DIVIDE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_INTERVAL = 2'd2;

    localparam logic [7:0] SAMPLE_DIVIDE_RESET  = 8'd10;
    localparam logic [7:0] DECAY_INTERVAL_RESET = 8'd5;
    localparam logic [7:0] FLOOR_OFFSET         = 8'd160;

    typedef struct packed {
        logic capture;
        logic count_tick;
        logic sample_read;
        logic sample_write;
        logic decay_start;
        logic decay_step;
        logic render_read;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_render;
        logic tick_live;
        logic sample_due;
        logic decay_due;
        logic decay_done;
        logic out_free;
    } ctrl_stat_t;

endpackage

/* src/scrolling_level_scope_peak_hold_top.sv */
// Top level of the scrolling level scope with peak hold.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  in      | input     | in_valid/in_stall  | kind rssi_raw transmitting floor_valid
//          |           |                    | floor_dbm column
//  out     | output    | out_valid/out_stall| column_pixels
//  cfg     | input     | cfg_write          | cfg_index cfg_data
//
//  A render beat steps through accept, memory read and pixel load into the output register.
//  A tick passes through accept and decode; a sample tick adds a write to the column memory, and
//  a decay pass then walks the column memory (one slot read and at most one written back per cycle).
//  Reset clears the per-slot valid bits at once, so there is no clearing pass; writing
//  scope_enable low does the same.
//  A stalled output holds its render in the output register; the next render waits in the
//  memory read register and stalls the input until the output register is taken.
module scrolling_level_scope_peak_hold_top #(
    parameter int COLUMNS = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [slsph_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slsph_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              kind,
    input  logic [8:0]                        rssi_raw,
    input  logic                              transmitting,
    input  logic                              floor_valid,
    input  logic signed [8:0]                 floor_dbm,
    input  logic [6:0]                        column,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        column_pixels
);
    import slsph_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    slsph_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    slsph_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .rssi_raw      (rssi_raw),
        .transmitting  (transmitting),
        .floor_valid   (floor_valid),
        .floor_dbm     (floor_dbm),
        .column        (column),
        .cmd           (cmd),
        .stat          (stat),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .column_pixels (column_pixels)
    );

    // an accepted beat moves the sequencer out of idle, so the input stalls while it is decoded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while previous beat still decoding");

    // a new result only appears through a render load
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("output valid rose without a render load");

    // decay walk follows its start directly
    a_decay_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decay_start |=> cmd.decay_step)
        else $error("decay pass did not start walking");

    // the column memory never sees two writers in one cycle
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sample_write |-> !cmd.decay_step)
        else $error("sample write collides with decay walk");

endmodule

/* src/slsph_ctrl.sv */
// Sequencer: decodes each beat and steps the datapath through render, sample and decay.
module slsph_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  slsph_pkg::ctrl_stat_t stat,
    output slsph_pkg::ctrl_cmd_t  cmd
);
    import slsph_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_RENDER = 5'b00100,
        ST_SAMPLE = 5'b01000,
        ST_DECAY  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_render)
                begin
                    cmd.render_read = 1'b1;
                    state_next      = ST_RENDER;
                end
                else if (stat.tick_live)
                begin
                    cmd.count_tick = 1'b1;
                    if (stat.sample_due)
                    begin
                        cmd.sample_read = 1'b1;
                        state_next      = ST_SAMPLE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RENDER:
            begin
                // hold the read data until the output register frees up
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SAMPLE:
            begin
                cmd.sample_write = 1'b1;
                if (stat.decay_due)
                begin
                    cmd.decay_start = 1'b1;
                    state_next      = ST_DECAY;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DECAY:
            begin
                cmd.decay_step = 1'b1;
                if (stat.decay_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

/* src/slsph_dp.sv */
// Datapath: config registers, counters, circular column memory and pixel render.
module slsph_dp #(
    parameter int COLUMNS = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [slsph_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [slsph_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              kind,
    input  logic [8:0]                        rssi_raw,
    input  logic                              transmitting,
    input  logic                              floor_valid,
    input  logic signed [8:0]                 floor_dbm,
    input  logic [6:0]                        column,
    input  slsph_pkg::ctrl_cmd_t              cmd,
    output slsph_pkg::ctrl_stat_t             stat,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [7:0]                        column_pixels
);
    import slsph_pkg::*;

    localparam int AW = $clog2(COLUMNS);
    localparam int WW = AW + 1;
    localparam int SW = ((AW > 7) ? AW : 7) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(COLUMNS - 1);

    // config
    logic       enable_reg;
    logic [7:0] divide_reg;
    logic [7:0] interval_reg;

    // captured beat
    logic       kind_reg;
    logic       tx_reg;
    logic       fvalid_reg;
    logic [7:0] fdbm_reg;
    logic [7:0] level_reg;
    logic [6:0] col_reg;

    // counters and scroll position
    logic [7:0]    tick_reg;
    logic [7:0]    decay_reg;
    logic [7:0]    floor_reg;
    logic [AW-1:0] head_reg;
    logic [WW-1:0] walk_reg;
    logic          pend_reg;
    logic [AW-1:0] waddr_reg;

    // column memory: {level, peak}
    logic [15:0]        mem [COLUMNS];
    logic [15:0]        rd_data_reg;
    logic               rd_valid_reg;
    logic [COLUMNS-1:0] valid_reg;

    logic          out_valid_reg;
    logic [7:0]    pixels_reg;

    logic [7:0]    tick_inc;
    logic [7:0]    decay_inc;
    logic [AW-1:0] newest_addr;
    logic [AW-1:0] head_inc;
    logic [SW-1:0] col_w;
    logic [SW-1:0] col_sum;
    logic [SW-1:0] col_wrap;
    logic          in_range;
    logic [AW-1:0] render_addr;
    logic          walk_live;
    logic [7:0]    cur_level;
    logic [7:0]    cur_peak;
    logic [7:0]    new_peak;
    logic          decay_wr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          clear_all;
    logic [2:0]    sig_h;
    logic [2:0]    peak_h;
    logic [2:0]    nf_h;
    logic [7:0]    pixels_next;

    assign clear_all = cfg_write && (cfg_index == CFG_SCOPE_ENABLE) && !cfg_data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b0;
            divide_reg   <= SAMPLE_DIVIDE_RESET;
            interval_reg <= DECAY_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SCOPE_ENABLE:   enable_reg   <= cfg_data[0];
                CFG_SAMPLE_DIVIDE:  divide_reg   <= cfg_data;
                CFG_DECAY_INTERVAL: interval_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            tx_reg     <= transmitting;
            fvalid_reg <= floor_valid;
            fdbm_reg   <= floor_dbm[7:0];
            level_reg  <= rssi_raw[8:1];
            col_reg    <= column;
        end
    end

    assign tick_inc    = tick_reg + 8'd1;
    assign decay_inc   = decay_reg + 8'd1;
    assign newest_addr = (head_reg == '0) ? LAST_ADDR : head_reg - AW'(1);
    assign head_inc    = (head_reg == LAST_ADDR) ? '0 : head_reg + AW'(1);

    // logical column -> physical slot, head holds the oldest column
    assign col_w       = SW'(col_reg);
    assign in_range    = col_w < SW'(COLUMNS);
    assign col_sum     = SW'(head_reg) + col_w;
    assign col_wrap    = (col_sum >= SW'(COLUMNS)) ? col_sum - SW'(COLUMNS) : col_sum;
    assign render_addr = col_wrap[AW-1:0];

    assign walk_live = walk_reg < WW'(COLUMNS);

    // entries never written since the last clear read as zero
    assign cur_level = rd_valid_reg ? rd_data_reg[15:8] : 8'd0;
    assign cur_peak  = rd_valid_reg ? rd_data_reg[7:0] : 8'd0;
    assign new_peak  = (level_reg > cur_peak) ? level_reg : cur_peak;
    assign decay_wr  = cmd.decay_step && pend_reg && (cur_peak > cur_level) && (cur_peak != 8'd0);

    always_comb
    begin
        rd_en   = cmd.render_read || cmd.sample_read || (cmd.decay_step && walk_live);
        rd_addr = walk_reg[AW-1:0];
        if (cmd.render_read)
        begin
            rd_addr = render_addr;
        end
        else if (cmd.sample_read)
        begin
            rd_addr = newest_addr;
        end
    end

    always_comb
    begin
        wr_en   = cmd.sample_write || decay_wr;
        wr_addr = waddr_reg;
        wr_data = {cur_level, cur_peak - 8'd1};
        if (cmd.sample_write)
        begin
            wr_addr = head_reg;
            wr_data = {level_reg, new_peak};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear_all)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= '0;
            decay_reg <= '0;
            floor_reg <= '0;
            head_reg  <= '0;
            walk_reg  <= '0;
            pend_reg  <= 1'b0;
            waddr_reg <= '0;
        end
        else
        begin
            if (cmd.sample_read)
            begin
                tick_reg <= '0;
                if (fvalid_reg)
                begin
                    floor_reg <= fdbm_reg + FLOOR_OFFSET;
                end
            end
            else if (cmd.count_tick)
            begin
                tick_reg <= tick_inc;
            end

            if (cmd.sample_write)
            begin
                head_reg  <= head_inc;
                decay_reg <= stat.decay_due ? 8'd0 : decay_inc;
            end

            if (cmd.decay_start)
            begin
                walk_reg <= '0;
                pend_reg <= 1'b0;
            end
            else if (cmd.decay_step)
            begin
                // read slot k while writing back slot k-1
                pend_reg  <= walk_live;
                waddr_reg <= walk_reg[AW-1:0];
                if (walk_live)
                begin
                    walk_reg <= walk_reg + WW'(1);
                end
            end
        end
    end

    assign sig_h  = cur_level[7:5];
    assign peak_h = cur_peak[7:5];
    assign nf_h   = floor_reg[7:5];

    always_comb
    begin
        pixels_next = ~(8'hFF << sig_h);
        if (peak_h > sig_h)
        begin
            pixels_next = pixels_next | (8'd1 << peak_h);
        end
        if ((col_reg[1:0] == 2'd0) && (nf_h != 3'd0))
        begin
            pixels_next = pixels_next | (8'd1 << nf_h);
        end
        if (!in_range)
        begin
            pixels_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pixels_reg <= pixels_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign column_pixels = pixels_reg;

    assign stat.is_render  = kind_reg;
    assign stat.tick_live  = enable_reg && !tx_reg;
    assign stat.sample_due = tick_inc >= divide_reg;
    assign stat.decay_due  = decay_inc >= interval_reg;
    assign stat.decay_done = !walk_live;
    assign stat.out_free   = !out_valid_reg || !out_stall;

endmodule
